// ===== rtl/number_punct_symbol_classifier_macros.svh =====
// Assertion macros shared by the classifier RTL.
// Self-contained: no dependencies on other files.
`ifndef NUMBER_PUNCT_SYMBOL_CLASSIFIER_MACROS_SVH
`define NUMBER_PUNCT_SYMBOL_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NPSC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/npsc_pkg.sv =====
// Types and constants for the number, punctuation and symbol classifier.
// No dependencies; used by npsc_step and number_punct_symbol_classifier.
package npsc_pkg;

   localparam int CP_WIDTH = 21;

   localparam logic [CP_WIDTH-1:0] CP_PLUS  = 21'h00002B;
   localparam logic [CP_WIDTH-1:0] CP_MINUS = 21'h00002D;
   localparam logic [CP_WIDTH-1:0] CP_DOT   = 21'h00002E;
   localparam logic [CP_WIDTH-1:0] CP_COMMA = 21'h00002C;
   localparam logic [CP_WIDTH-1:0] CP_E_LO  = 21'h000065;
   localparam logic [CP_WIDTH-1:0] CP_E_UP  = 21'h000045;

   typedef enum logic [1:0] {
      CAT_OTHER  = 2'd0,
      CAT_NUMBER = 2'd1,
      CAT_PUNCT  = 2'd2,
      CAT_SYMBOL = 2'd3
   } npsc_cat_type;

   typedef enum logic [1:0] {
      CLASS_NONE   = 2'd0,
      CLASS_NUMBER = 2'd1,
      CLASS_PUNCT  = 2'd2,
      CLASS_SYMBOL = 2'd3
   } npsc_class_type;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_INT    = 3'd1,
      PH_FRAC   = 3'd2,
      PH_EXP    = 3'd3,
      PH_EXPDIG = 3'd4,
      PH_REJECT = 3'd5
   } npsc_phase_type;

   typedef struct packed {
      npsc_phase_type phase;
      logic           digit_seen;
      logic           all_punct;
      logic           all_symbol;
   } npsc_state_type;

   typedef struct packed {
      npsc_class_type form_class;
      logic           drop_trailing_dot;
   } npsc_result_type;

   localparam npsc_state_type STATE_RESET = '{
      phase:      PH_START,
      digit_seen: 1'b0,
      all_punct:  1'b1,
      all_symbol: 1'b1
   };

endpackage

// ===== rtl/npsc_step.sv =====
// Combinational step of the classifier: number grammar and class flags.
// Depends on npsc_pkg.
module npsc_step (
   input  npsc_pkg::npsc_state_type              state_cur,
   input  logic [npsc_pkg::CP_WIDTH-1:0]         codepoint,
   input  logic [1:0]                            category,
   input  logic                                  last,
   output npsc_pkg::npsc_state_type              state_nxt,
   output npsc_pkg::npsc_result_type             result
);
   import npsc_pkg::*;

   npsc_phase_type ph;
   npsc_phase_type ph_nxt;
   logic           dseen;
   logic           consumed;
   logic           done;
   logic           active;
   logic           digit;
   logic           is_sign;
   logic           is_exp;
   logic           is_dot;
   logic           all_p;
   logic           all_s;
   logic           is_number;
   logic           drop;

   always_comb begin
      digit   = (category == CAT_NUMBER);
      is_sign = (codepoint == CP_PLUS) || (codepoint == CP_MINUS);
      is_exp  = (codepoint == CP_E_LO) || (codepoint == CP_E_UP);
      is_dot  = (codepoint == CP_DOT);
      all_p   = state_cur.all_punct && (category == CAT_PUNCT);
      all_s   = state_cur.all_symbol && (category == CAT_SYMBOL);
      active  = (state_cur.phase != PH_REJECT);

      ph       = state_cur.phase;
      ph_nxt   = state_cur.phase;
      dseen    = state_cur.digit_seen;
      consumed = 1'b0;
      done     = !active;

      if (!done && ph == PH_START) begin
         if (is_sign) begin
            ph_nxt   = PH_INT;
            consumed = 1'b1;
            done     = 1'b1;
         end else begin
            ph = PH_INT;
         end
      end
      if (!done && ph == PH_INT) begin
         if (digit) begin
            dseen    = 1'b1;
            ph_nxt   = PH_INT;
            consumed = 1'b1;
            done     = 1'b1;
         end else if ((is_dot && !last) || codepoint == CP_COMMA) begin
            ph_nxt   = PH_FRAC;
            consumed = 1'b1;
            done     = 1'b1;
         end else begin
            ph = PH_FRAC;
         end
      end
      if (!done && ph == PH_FRAC) begin
         done = 1'b1;
         if (digit) begin
            dseen    = 1'b1;
            ph_nxt   = PH_FRAC;
            consumed = 1'b1;
         end else if (dseen && is_exp) begin
            dseen    = 1'b0;
            ph_nxt   = PH_EXP;
            consumed = 1'b1;
         end
      end
      if (!done && ph == PH_EXP) begin
         done = 1'b1;
         if (is_sign || digit) begin
            if (digit) begin
               dseen = 1'b1;
            end
            ph_nxt   = PH_EXPDIG;
            consumed = 1'b1;
         end
      end
      if (!done && ph == PH_EXPDIG) begin
         if (digit) begin
            dseen    = 1'b1;
            consumed = 1'b1;
         end
      end

      is_number = 1'b0;
      drop      = 1'b0;
      if (active) begin
         if (last) begin
            if (consumed) begin
               is_number = dseen;
            end else if (dseen && is_dot) begin
               is_number = 1'b1;
               drop      = 1'b1;
            end
         end else if (!consumed) begin
            ph_nxt = PH_REJECT;
         end
      end

      if (is_number) begin
         result.form_class = CLASS_NUMBER;
      end else if (all_p) begin
         result.form_class = CLASS_PUNCT;
      end else if (all_s) begin
         result.form_class = CLASS_SYMBOL;
      end else begin
         result.form_class = CLASS_NONE;
      end
      result.drop_trailing_dot = drop;

      if (last) begin
         state_nxt = STATE_RESET;
      end else begin
         state_nxt.phase      = ph_nxt;
         state_nxt.digit_seen = dseen;
         state_nxt.all_punct  = all_p;
         state_nxt.all_symbol = all_s;
      end
   end

endmodule

// ===== rtl/number_punct_symbol_classifier.sv =====
// Top level of the number, punctuation and symbol classifier.
// Depends on npsc_pkg, npsc_step and number_punct_symbol_classifier_macros.svh.
//
//   Channel | Direction | Payload
//   req     | in        | tdata: codepoint; tuser: category; tlast: final codepoint
//   rsp     | out       | tdata: form_class, drop_trailing_dot
//
// One codepoint is taken per cycle unless a final codepoint waits on a stalled result; a word's
// result is registered once its final codepoint has left the input register through the step logic.
// Reset clears the word state and both valid flags.
// A stalled result holds only final codepoints back; others keep flowing.
module number_punct_symbol_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] codepoint, [23:21] zero
   input  logic [1:0]  req_tuser,   // [1:0] category
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] form_class, [2] drop_trailing_dot, [7:3] zero
);
   import npsc_pkg::*;
   `include "number_punct_symbol_classifier_macros.svh"

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [CP_WIDTH-1:0] in_cp_ff;
   logic [1:0]          in_cat_ff;
   logic                in_last_ff;
   npsc_state_type      state_ff;
   npsc_state_type      state_in;
   npsc_state_type      step_nxt;
   npsc_result_type     step_result;
   logic                out_valid_ff;
   logic                out_valid_in;
   npsc_result_type     out_result_ff;
   logic                out_free;
   logic                s1_fire;
   logic                req_fire;

   npsc_step u_step (
      .state_cur (state_ff),
      .codepoint (in_cp_ff),
      .category  (in_cat_ff),
      .last      (in_last_ff),
      .state_nxt (step_nxt),
      .result    (step_result)
   );

   always_comb begin
      out_free   = !out_valid_ff || rsp_tready;
      s1_fire    = in_valid_ff && (!in_last_ff || out_free);
      req_tready = !in_valid_ff || s1_fire;
      req_fire   = req_tvalid && req_tready;

      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (s1_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      state_in = s1_fire ? step_nxt : state_ff;

      if (s1_fire && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cp_ff   <= req_tdata[CP_WIDTH-1:0];
         in_cat_ff  <= req_tuser;
         in_last_ff <= req_tlast;
      end
      if (s1_fire && in_last_ff) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_result_ff.drop_trailing_dot, out_result_ff.form_class};

   `NPSC_ASSERT_IMPLY(a_drop_only_number, clock, reset,
      rsp_tvalid && rsp_tdata[2], rsp_tdata[1:0] == CLASS_NUMBER,
      "Trailing dot dropped on a form that is not a number.")
   `NPSC_ASSERT_NEXT(a_state_cleared, clock, reset,
      s1_fire && in_last_ff, state_ff == STATE_RESET,
      "Word state not cleared after the final codepoint.")
   `NPSC_ASSERT_NEXT(a_reject_sticky, clock, reset,
      state_ff.phase == PH_REJECT && !(s1_fire && in_last_ff), state_ff.phase == PH_REJECT,
      "Rejected number grammar left before the end of the word.")
   `NPSC_ASSERT_IMPLY(a_no_overwrite, clock, reset,
      s1_fire && in_last_ff, !out_valid_ff || rsp_tready,
      "Result register overwritten while its transaction was pending.")

endmodule

// ===== verif/tb_number_punct_symbol_classifier.sv =====
// Self-checking testbench for number_punct_symbol_classifier: drives words codepoint by
// codepoint, predicts each word's class in a scoreboard and checks every result.
// Depends on npsc_pkg and the RTL of number_punct_symbol_classifier.
`timescale 1ns / 100ps

module tb_number_punct_symbol_classifier;
   import npsc_pkg::*;

   localparam int WORD_ITEMS  = 1200;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN       = 10;
   localparam int CYCLE_LIMIT = 100000;

   typedef struct packed {
      logic [CP_WIDTH-1:0] cp;
      npsc_cat_type        cat;
   } char_item_type;

   class word_class_scoreboard;
      npsc_phase_type  phase;
      bit              digit_seen;
      bit              all_punct;
      bit              all_symbol;
      npsc_result_type expected_q[$];
      int              errors;

      function new();
         clear_word();
         errors = 0;
      endfunction

      function void clear_word();
         phase      = PH_START;
         digit_seen = 1'b0;
         all_punct  = 1'b1;
         all_symbol = 1'b1;
      endfunction

      function bit is_sign(logic [CP_WIDTH-1:0] cp);
         return cp == CP_PLUS || cp == CP_MINUS;
      endfunction

      // Moves the number grammar on by one codepoint; returns 0 when it stops the match.
      function bit advance_grammar(logic [CP_WIDTH-1:0] cp, bit digit, bit fin);
         npsc_phase_type ph;
         ph = phase;
         if (ph == PH_START) begin
            if (is_sign(cp)) begin
               phase = PH_INT;
               return 1'b1;
            end
            ph = PH_INT;
         end
         if (ph == PH_INT) begin
            if (digit) begin
               digit_seen = 1'b1;
               phase      = PH_INT;
               return 1'b1;
            end
            if ((cp == CP_DOT && !fin) || cp == CP_COMMA) begin
               phase = PH_FRAC;
               return 1'b1;
            end
            ph = PH_FRAC;
         end
         case (ph)
            PH_FRAC: begin
               if (digit) begin
                  digit_seen = 1'b1;
                  phase      = PH_FRAC;
                  return 1'b1;
               end
               if (digit_seen && (cp == CP_E_LO || cp == CP_E_UP)) begin
                  digit_seen = 1'b0;
                  phase      = PH_EXP;
                  return 1'b1;
               end
               return 1'b0;
            end
            PH_EXP: begin
               if (is_sign(cp) || digit) begin
                  if (digit) digit_seen = 1'b1;
                  phase = PH_EXPDIG;
                  return 1'b1;
               end
               return 1'b0;
            end
            PH_EXPDIG: begin
               if (digit) begin
                  digit_seen = 1'b1;
                  return 1'b1;
               end
               return 1'b0;
            end
            default: return 1'b0;
         endcase
      endfunction

      function void note_input(logic [CP_WIDTH-1:0] cp, npsc_cat_type cat, bit fin);
         bit              consumed;
         bit              is_number;
         bit              drop;
         npsc_result_type res;
         is_number  = 1'b0;
         drop       = 1'b0;
         all_punct  = all_punct && cat == CAT_PUNCT;
         all_symbol = all_symbol && cat == CAT_SYMBOL;
         if (phase != PH_REJECT) begin
            consumed = advance_grammar(cp, cat == CAT_NUMBER, fin);
            if (fin) begin
               if (consumed) begin
                  is_number = digit_seen;
               end else if (digit_seen && cp == CP_DOT) begin
                  is_number = 1'b1;
                  drop      = 1'b1;
               end
            end else if (!consumed) begin
               phase = PH_REJECT;
            end
         end
         if (fin) begin
            if (is_number)       res.form_class = CLASS_NUMBER;
            else if (all_punct)  res.form_class = CLASS_PUNCT;
            else if (all_symbol) res.form_class = CLASS_SYMBOL;
            else                 res.form_class = CLASS_NONE;
            res.drop_trailing_dot = drop;
            expected_q.push_back(res);
            clear_word();
         end
      endfunction

      function void check_result(npsc_result_type got);
         npsc_result_type exp_res;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result transaction, expected none, got class %0d drop %0d",
                     $time, got.form_class, got.drop_trailing_dot);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         if (got.form_class !== exp_res.form_class) begin
            $display("%0t: form_class mismatch, expected %0d, got %0d",
                     $time, exp_res.form_class, got.form_class);
            errors++;
         end
         if (got.drop_trailing_dot !== exp_res.drop_trailing_dot) begin
            $display("%0t: drop_trailing_dot mismatch, expected %0d, got %0d",
                     $time, exp_res.drop_trailing_dot, got.drop_trailing_dot);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [20:0] codepoint, [23:21] zero
   logic [1:0]  req_tuser = '0;   // [1:0] category
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [1:0] form_class, [2] drop_trailing_dot, [7:3] zero

   word_class_scoreboard sb;
   char_item_type        word_q[$];
   int                   items_sent = 0;
   int                   cycle_count = 0;
   bit                   rush = 1'b0;
   bit                   hold_request = 1'b0;

   number_punct_symbol_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      npsc_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_input(req_tdata[CP_WIDTH-1:0], npsc_cat_type'(req_tuser), req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.form_class        = npsc_class_type'(rsp_tdata[1:0]);
            got.drop_trailing_dot = rsp_tdata[2];
            sb.check_result(got);
         end
      end
   end

   function automatic int draw_gap();
      return rush ? 0 : $urandom_range(0, 4);
   endfunction

   // Grammar marks and ASCII digits turn up often, the rest of the code space otherwise.
   function automatic logic [CP_WIDTH-1:0] random_cp();
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 6))
               0: return CP_PLUS;
               1: return CP_MINUS;
               2: return CP_DOT;
               3: return CP_COMMA;
               4: return CP_E_LO;
               5: return CP_E_UP;
               default: return '0;
            endcase
         end
         1: return CP_WIDTH'(32'h30 + $urandom_range(0, 9));
         default: return CP_WIDTH'($urandom_range(0, 32'h10FFFF));
      endcase
   endfunction

   function automatic npsc_cat_type mark_cat();
      return npsc_cat_type'($urandom_range(CAT_PUNCT, CAT_SYMBOL));
   endfunction

   function automatic void put(logic [CP_WIDTH-1:0] cp, npsc_cat_type cat);
      word_q.push_back('{cp: cp, cat: cat});
   endfunction

   function automatic void add_digits(int n);
      repeat (n) put(random_cp(), CAT_NUMBER);
   endfunction

   function automatic void build_number();
      if ($urandom_range(0, 2) == 0) put($urandom_range(0, 1) ? CP_PLUS : CP_MINUS, mark_cat());
      add_digits($urandom_range(0, 3));
      if ($urandom_range(0, 1)) begin
         put($urandom_range(0, 1) ? CP_DOT : CP_COMMA, mark_cat());
         add_digits($urandom_range(0, 3));
      end
      if ($urandom_range(0, 2) == 0) begin
         put($urandom_range(0, 1) ? CP_E_LO : CP_E_UP, CAT_OTHER);
         if ($urandom_range(0, 1)) put($urandom_range(0, 1) ? CP_PLUS : CP_MINUS, mark_cat());
         add_digits($urandom_range(0, 2));
      end
      if ($urandom_range(0, 3) == 0) put(CP_DOT, CAT_PUNCT);
      if (word_q.size() == 0) add_digits(1);
   endfunction

   task automatic send_word();
      int gap;
      for (int i = 0; i < word_q.size(); i++) begin
         gap = draw_gap();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {3'b000, word_q[i].cp};
         req_tuser  <= word_q[i].cat;
         req_tlast  <= (i == word_q.size() - 1);
         do @(posedge clock); while (!req_tready);
         items_sent++;
      end
      word_q.delete();
   endtask

   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            stall = draw_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      int kind;
      int n;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      put(21'h35, CAT_NUMBER);
      send_word();
      put(CP_MINUS, CAT_PUNCT);
      put(21'h31, CAT_NUMBER);
      put(CP_DOT, CAT_PUNCT);
      put(21'h35, CAT_NUMBER);
      put(CP_E_LO, CAT_OTHER);
      put(CP_PLUS, CAT_SYMBOL);
      put(21'h33, CAT_NUMBER);
      send_word();
      // A final full stop after digits is kept out of the number.
      put(21'h31, CAT_NUMBER);
      put(21'h32, CAT_NUMBER);
      put(CP_DOT, CAT_PUNCT);
      send_word();
      put(CP_DOT, CAT_PUNCT);
      send_word();
      put(CP_PLUS, CAT_SYMBOL);
      send_word();
      put('0, CAT_OTHER);
      send_word();
      put(21'h10FFFF, CAT_NUMBER);
      send_word();
      put(21'h31, CAT_NUMBER);
      put(CP_COMMA, CAT_PUNCT);
      put(21'h32, CAT_NUMBER);
      send_word();
      put(CP_E_UP, CAT_OTHER);
      put(21'h35, CAT_NUMBER);
      send_word();
      put(21'h31, CAT_NUMBER);
      put(CP_E_LO, CAT_OTHER);
      send_word();

      // The receiver holds off while the sender keeps offering, so final codepoints back up.
      rush         = 1'b1;
      hold_request = 1'b1;
      while (items_sent < WORD_ITEMS) begin
         if ($urandom_range(0, 11) == 0) rush = !rush;
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            build_number();
            if ($urandom_range(0, 4) == 0)
               word_q[$urandom_range(0, word_q.size() - 1)] =
                  '{cp: random_cp(), cat: npsc_cat_type'($urandom_range(0, 3))};
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               case (kind)
                  6:       put(random_cp(), CAT_PUNCT);
                  7:       put(random_cp(), CAT_SYMBOL);
                  default: put(random_cp(), npsc_cat_type'($urandom_range(0, 3)));
               endcase
            end
         end
         send_word();
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/npsc_pkg.sv
rtl/npsc_step.sv
rtl/number_punct_symbol_classifier.sv
verif/tb_number_punct_symbol_classifier.sv
